@@ rtl/mmv_pkg.sv @@
// Package for the MIDI message validator: byte item type, status constants
// and the expected message length table. No dependencies.

package mmv_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 3;
    localparam int LEN_W   = 3;
    localparam int TAB_N   = 23;
    localparam int IDX_W   = $clog2(TAB_N);

    localparam logic [BYTE_W-1:0]  SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0]  SYSEX_END   = 8'hF7;
    localparam logic [BYTE_W-1:0]  SYS_MASK    = 8'hF0;
    localparam logic [3:0]         SYS_BASE    = 4'h7;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 3'd4;

    // Index 0..6: channel messages 0x8n..0xEn; 7..22: system messages 0xF0..0xFF.
    // Zero marks undefined codes.
    localparam logic [LEN_W-1:0] MSG_LEN [TAB_N] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd0,
        3'd2, 3'd3, 3'd2, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1,
        3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1, 3'd1
    };

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_item_t;

    function automatic logic [LEN_W-1:0] expected_len(input logic [BYTE_W-1:0] status);
        logic [IDX_W-1:0] idx;
        if ((status & SYS_MASK) != SYS_MASK)
            idx = {2'b00, status[6:4]};
        else
            idx = {1'b0, status[3:0]} + {1'b0, SYS_BASE};
        return MSG_LEN[idx];
    endfunction

endpackage

@@ rtl/mmv_input_stage.sv @@
// Input register stage of the MIDI message validator.
// Depends on mmv_pkg for the byte item type.

module mmv_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mmv_pkg::byte_item_t in_item,
    output logic                s1_valid,
    input  logic                s1_take,
    output mmv_pkg::byte_item_t s1_item
);

    logic                valid_reg;
    mmv_pkg::byte_item_t item_reg;

    assign in_ready = !valid_reg || s1_take;
    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/mmv_checker.sv @@
// Message state tracking, length/format judgment and result register.
// Depends on mmv_pkg for the length table and byte item type.

module mmv_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    output logic                              s1_take,
    input  mmv_pkg::byte_item_t               s1_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              valid_res,
    output logic [mmv_pkg::BYTE_W-1:0]        status_byte
);

    logic [mmv_pkg::BYTE_W-1:0]  first_byte_reg, first_byte_next;
    logic [mmv_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic                        middle_ok_reg, middle_ok_next;
    logic                        res_valid_reg;
    logic                        res_ok_reg;
    logic [mmv_pkg::BYTE_W-1:0]  res_status_reg;

    logic                        slot_free;
    logic [mmv_pkg::BYTE_W-1:0]  b;
    logic [mmv_pkg::BYTE_W-1:0]  status;
    logic [mmv_pkg::LEN_W-1:0]   len;
    logic                        ok;
    logic                        emit;

    assign slot_free = !res_valid_reg || out_ready;
    // Non-final bytes never need the result slot.
    assign s1_take   = s1_valid && (!s1_item.last || slot_free);
    assign emit      = s1_take && s1_item.last;
    assign b         = s1_item.data;

    always_comb
    begin
        first_byte_next = (byte_count_reg == '0) ? b : first_byte_reg;
        status          = first_byte_next;
        len             = (byte_count_reg < mmv_pkg::COUNT_SAT) ?
                          (byte_count_reg + 3'd1) : mmv_pkg::COUNT_SAT;

        if (!status[7])
            ok = 1'b0;
        else if (status == mmv_pkg::SYSEX_START)
            ok = (len >= 3'd3) && (b == mmv_pkg::SYSEX_END) && middle_ok_reg;
        else if (len != mmv_pkg::expected_len(status))
            ok = 1'b0;
        else if (len == 3'd1)
            ok = 1'b1;
        else
            ok = middle_ok_reg && !b[7];

        if (s1_item.last)
        begin
            byte_count_next = '0;
            middle_ok_next  = 1'b1;
        end
        else
        begin
            byte_count_next = (byte_count_reg < mmv_pkg::COUNT_SAT) ?
                              (byte_count_reg + 3'd1) : byte_count_reg;
            middle_ok_next  = middle_ok_reg && !((byte_count_reg != '0) && b[7]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_byte_reg <= '0;
            byte_count_reg <= '0;
            middle_ok_reg  <= 1'b1;
        end
        else if (s1_take)
        begin
            first_byte_reg <= first_byte_next;
            byte_count_reg <= byte_count_next;
            middle_ok_reg  <= middle_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            res_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_ok_reg     <= ok;
            res_status_reg <= status;
        end
    end

    assign out_valid   = res_valid_reg;
    assign valid_res   = res_ok_reg;
    assign status_byte = res_status_reg;

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= mmv_pkg::COUNT_SAT)
        else $error("byte count beyond saturation");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (byte_count_reg == '0) && middle_ok_reg)
        else $error("message state not cleared after final byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready && s1_take) |-> !s1_item.last)
        else $error("pending result overwritten");

endmodule

@@ rtl/midi_message_validator.sv @@
// Top level of the MIDI 1.0 message validator.
// Depends on mmv_pkg, mmv_input_stage and mmv_checker.
//
// channel   signals                          transfer when
// input     data_byte, last                  in_valid && in_ready
// result    valid_res, status_byte           out_valid && out_ready
//
// One byte per cycle sustained while no final byte waits on a full result
// register; a final byte passes the input register, then the result
// register, before out_valid rises and the result can transfer.
// Bytes with last low produce no result and pass even while a result stalls.
// A final byte waits in the input register while the result register is full.
// Reset clears the message state: count 0, middle flag set, first byte 0.

module midi_message_validator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mmv_pkg::BYTE_W-1:0] data_byte,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       valid_res,
    output logic [mmv_pkg::BYTE_W-1:0] status_byte
);

    mmv_pkg::byte_item_t in_item;
    mmv_pkg::byte_item_t s1_item;
    logic                s1_valid;
    logic                s1_take;

    assign in_item.data = data_byte;
    assign in_item.last = last;

    mmv_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .s1_valid (s1_valid),
        .s1_take  (s1_take),
        .s1_item  (s1_item)
    );

    mmv_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1_take     (s1_take),
        .s1_item     (s1_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .valid_res   (valid_res),
        .status_byte (status_byte)
    );

endmodule
